// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the bounding box normalizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bbn_pkg.sv =====
// Shared constants, types and control structs of the bounding box normalizer.
package bbn_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int STORE_W      = 3 * COORD_WIDTH;
  localparam int NORM_W       = 16;
  localparam int FRAC_BITS    = 14;
  localparam int Q_BITS       = FRAC_BITS + 1;
  localparam int STEP_W       = $clog2(Q_BITS);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] ext_t;
  typedef logic signed [NORM_W-1:0]      norm_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic upd;
    logic clr;
    logic start;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic ext_load;
    logic out_load;
    logic out_last;
  } merge_ctrl_t;

endpackage

// ===== hw/rtl/bbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bbn_lane.sv =====
// One axis lane: bounds tracking, centered numerator and restoring divider.
`include "assert_macros.svh"

module bbn_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  bbn_pkg::lane_ctrl_t ctrl,
  input  bbn_pkg::coord_t     pos,
  input  bbn_pkg::coord_t     stored,
  input  bbn_pkg::ext_t       ext,
  output bbn_pkg::ext_t       axis_ext,
  output bbn_pkg::norm_t      norm
);

  localparam int W = bbn_pkg::COORD_WIDTH;
  localparam int Q = bbn_pkg::Q_BITS;

  bbn_pkg::coord_t min_r;
  bbn_pkg::coord_t max_r;
  bbn_pkg::coord_t min_nxt;
  bbn_pkg::coord_t max_nxt;

  logic         neg_r;
  logic [W:0]   rem_r;
  logic [Q-1:0] quo_r;

  logic [W:0]   span;
  logic [W+1:0] num;
  logic [W+1:0] mag;
  logic         ge;
  logic [W:0]   rem_sub;
  logic [bbn_pkg::NORM_W-1:0] quo_ext;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctrl.clr) begin
      min_nxt = bbn_pkg::COORD_MAX;
      max_nxt = bbn_pkg::COORD_MIN;
    end else if (ctrl.upd) begin
      if (pos < min_r) min_nxt = pos;
      if (pos > max_r) max_nxt = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= bbn_pkg::COORD_MAX;
      max_r <= bbn_pkg::COORD_MIN;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign span     = {max_r[W-1], max_r} - {min_r[W-1], min_r};
  assign axis_ext = span[W-1:0];

  // The centered value 2p - min - max never exceeds the extent in magnitude.
  assign num = {stored[W-1], stored, 1'b0}
             - {{2{min_r[W-1]}}, min_r}
             - {{2{max_r[W-1]}}, max_r};
  assign mag = num[W+1] ? (~num + 1'b1) : num;

  assign ge      = (rem_r >= {1'b0, ext});
  assign rem_sub = ge ? (rem_r - {1'b0, ext}) : rem_r;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      neg_r <= num[W+1];
      rem_r <= mag[W:0];
      quo_r <= '0;
    end else if (ctrl.step) begin
      rem_r <= {rem_sub[W-1:0], 1'b0};
      quo_r <= {quo_r[Q-2:0], ge};
    end
  end

  assign quo_ext = {{(bbn_pkg::NORM_W-Q){1'b0}}, quo_r};
  assign norm    = neg_r ? -quo_ext : quo_ext;

  `ASSERT_ALWAYS(a_rem_below_twice_ext, !ctrl.step || (rem_r < {ext, 1'b0}))

endmodule

// ===== hw/rtl/bbn_merge.sv =====
// Merging stage: largest extent across lanes and the result register.
module bbn_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbn_pkg::merge_ctrl_t ctrl,
  input  bbn_pkg::ext_t        ext_x,
  input  bbn_pkg::ext_t        ext_y,
  input  bbn_pkg::ext_t        ext_z,
  input  bbn_pkg::norm_t       lane_x,
  input  bbn_pkg::norm_t       lane_y,
  input  bbn_pkg::norm_t       lane_z,
  output bbn_pkg::ext_t        ext,
  output logic                 degen,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbn_pkg::norm_t       out_norm_x,
  output bbn_pkg::norm_t       out_norm_y,
  output bbn_pkg::norm_t       out_norm_z,
  output logic                 out_degenerate,
  output logic                 out_last_out
);

  bbn_pkg::ext_t  ext_r;
  logic           degen_r;
  bbn_pkg::ext_t  ext_xy;
  bbn_pkg::ext_t  ext_max;
  logic           valid_r;
  bbn_pkg::norm_t nx_r;
  bbn_pkg::norm_t ny_r;
  bbn_pkg::norm_t nz_r;
  logic           dg_r;
  logic           last_r;

  assign ext_xy  = (ext_y > ext_x) ? ext_y : ext_x;
  assign ext_max = (ext_z > ext_xy) ? ext_z : ext_xy;

  always_ff @(posedge clk) begin
    if (ctrl.ext_load) begin
      ext_r   <= ext_max;
      degen_r <= (ext_max == '0);
    end
    if (ctrl.out_load) begin
      nx_r   <= degen_r ? '0 : lane_x;
      ny_r   <= degen_r ? '0 : lane_y;
      nz_r   <= degen_r ? '0 : lane_z;
      dg_r   <= degen_r;
      last_r <= ctrl.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign ext            = ext_r;
  assign degen          = degen_r;
  assign out_valid      = valid_r;
  assign out_norm_x     = nx_r;
  assign out_norm_y     = ny_r;
  assign out_norm_z     = nz_r;
  assign out_degenerate = dg_r;
  assign out_last_out   = last_r;

endmodule

// ===== hw/rtl/bounding_box_normalizer_top.sv =====
// Top level of the bounding box normalizer: vertex store, sequencer, lanes and merge.
//
// Vertices load at one word per cycle into a 64-entry store while three axis lanes
// track the bounds; a vertex that arrives with the store full is dropped. After the
// word marked last, the S_EXT state picks the largest extent, then each stored
// vertex is emitted in load order: store read, numerator setup, 15 steps of the
// restoring divider in each lane, one quotient bit per step, and the push into
// the result register; the divider steps are skipped when the extent is zero.
// Input is refused during emission and taken again as soon as the final result
// sits in the result register, even while it still waits.
`include "assert_macros.svh"

module bounding_box_normalizer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bbn_pkg::coord_t       in_pos_x,
  input  bbn_pkg::coord_t       in_pos_y,
  input  bbn_pkg::coord_t       in_pos_z,
  input  logic                  in_last_vertex,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bbn_pkg::norm_t        out_norm_x,
  output bbn_pkg::norm_t        out_norm_y,
  output bbn_pkg::norm_t        out_norm_z,
  output logic                  out_degenerate,
  output logic                  out_last_out
);

  localparam int W = bbn_pkg::COORD_WIDTH;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXT,
    S_READ,
    S_START,
    S_DIV,
    S_PUSH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [bbn_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [bbn_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [bbn_pkg::STEP_W-1:0]  step_r, step_nxt;

  bbn_pkg::lane_ctrl_t         lctrl;
  bbn_pkg::merge_ctrl_t        mctrl;

  logic                        accept;
  logic                        store_ok;
  logic                        we;
  logic                        is_last;
  logic [bbn_pkg::STORE_W-1:0] rdata;
  bbn_pkg::ext_t               ext_x, ext_y, ext_z, ext;
  bbn_pkg::norm_t              lane_x, lane_y, lane_z;
  logic                        degen;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign store_ok = (count_r < bbn_pkg::CNT_W'(bbn_pkg::MAX_VERTICES));
  assign we       = accept && store_ok;
  assign is_last  = ((idx_r + bbn_pkg::CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    lctrl          = '0;
    mctrl          = '0;
    lctrl.upd      = we;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (store_ok) count_nxt = count_r + bbn_pkg::CNT_W'(1);
          if (in_last_vertex) state_nxt = S_EXT;
        end
      end
      S_EXT: begin
        mctrl.ext_load = 1'b1;
        idx_nxt        = '0;
        state_nxt      = S_READ;
      end
      S_READ: begin
        state_nxt = S_START;
      end
      S_START: begin
        lctrl.start = 1'b1;
        step_nxt    = '0;
        state_nxt   = degen ? S_PUSH : S_DIV;
      end
      S_DIV: begin
        lctrl.step = 1'b1;
        step_nxt   = step_r + bbn_pkg::STEP_W'(1);
        if (step_r == bbn_pkg::STEP_W'(bbn_pkg::Q_BITS - 1)) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid || out_ready) begin
          mctrl.out_load = 1'b1;
          mctrl.out_last = is_last;
          if (is_last) begin
            lctrl.clr = 1'b1;
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + bbn_pkg::CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  bbn_ram #(
    .WIDTH(bbn_pkg::STORE_W),
    .DEPTH(bbn_pkg::MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[bbn_pkg::ADDR_W-1:0]),
    .wdata({in_pos_z, in_pos_y, in_pos_x}),
    .raddr(idx_r[bbn_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  bbn_lane u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lctrl),
    .pos     (in_pos_x),
    .stored  (rdata[W-1:0]),
    .ext     (ext),
    .axis_ext(ext_x),
    .norm    (lane_x)
  );

  bbn_lane u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lctrl),
    .pos     (in_pos_y),
    .stored  (rdata[2*W-1:W]),
    .ext     (ext),
    .axis_ext(ext_y),
    .norm    (lane_y)
  );

  bbn_lane u_lane_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lctrl),
    .pos     (in_pos_z),
    .stored  (rdata[3*W-1:2*W]),
    .ext     (ext),
    .axis_ext(ext_z),
    .norm    (lane_z)
  );

  bbn_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (mctrl),
    .ext_x         (ext_x),
    .ext_y         (ext_y),
    .ext_z         (ext_z),
    .lane_x        (lane_x),
    .lane_y        (lane_y),
    .lane_z        (lane_z),
    .ext           (ext),
    .degen         (degen),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_norm_x    (out_norm_x),
    .out_norm_y    (out_norm_y),
    .out_norm_z    (out_norm_z),
    .out_degenerate(out_degenerate),
    .out_last_out  (out_last_out)
  );

  `ASSERT_ALWAYS(a_idx_in_range, (state_r == S_LOAD) || (state_r == S_EXT) || (idx_r < count_r))
  `ASSERT_NEXT(a_final_clears, mctrl.out_load && mctrl.out_last, (count_r == '0) && in_ready)
  `ASSERT_ALWAYS(a_write_in_store, !we || (count_r < bbn_pkg::CNT_W'(bbn_pkg::MAX_VERTICES)))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the bounding box normalizer top level.
`timescale 1ns / 100ps

module testbench;

  typedef enum int {MESH_FULL, MESH_NARROW, MESH_FLAT, MESH_EXTREME} mesh_kind_t;

  typedef struct {
    bbn_pkg::coord_t x;
    bbn_pkg::coord_t y;
    bbn_pkg::coord_t z;
    logic            last;
    bit              hold;
    int              phase;
  } vertex_word_t;

  typedef struct {
    bbn_pkg::norm_t x;
    bbn_pkg::norm_t y;
    bbn_pkg::norm_t z;
    logic           degen;
    logic           last;
  } norm_word_t;

  logic            clk;
  logic            rst_n          = 1'b0;
  logic            in_valid       = 1'b0;
  logic            in_ready;
  bbn_pkg::coord_t in_pos_x       = '0;
  bbn_pkg::coord_t in_pos_y       = '0;
  bbn_pkg::coord_t in_pos_z       = '0;
  logic            in_last_vertex = 1'b0;
  logic            out_valid;
  logic            out_ready      = 1'b0;
  bbn_pkg::norm_t  out_norm_x;
  bbn_pkg::norm_t  out_norm_y;
  bbn_pkg::norm_t  out_norm_z;
  logic            out_degenerate;
  logic            out_last_out;

  vertex_word_t vertex_q[$];
  norm_word_t   norm_q[$];
  vertex_word_t cur_word;
  int           total_words = 0;
  int           taken_words = 0;
  int           err_count   = 0;
  int           drv_phase   = 0;

  bbn_pkg::coord_t mesh_x[bbn_pkg::MAX_VERTICES];
  bbn_pkg::coord_t mesh_y[bbn_pkg::MAX_VERTICES];
  bbn_pkg::coord_t mesh_z[bbn_pkg::MAX_VERTICES];
  int              mesh_count;
  bbn_pkg::coord_t lo_x, lo_y, lo_z;
  bbn_pkg::coord_t hi_x, hi_y, hi_z;

  bounding_box_normalizer_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_norm_x     (out_norm_x),
    .out_norm_y     (out_norm_y),
    .out_norm_z     (out_norm_z),
    .out_degenerate (out_degenerate),
    .out_last_out   (out_last_out)
  );

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bbn_pkg::norm_t scale_coord(bbn_pkg::coord_t p, bbn_pkg::coord_t lo,
                                                 bbn_pkg::coord_t hi, longint span);
    longint num;
    num = (2 * longint'(p) - longint'(lo) - longint'(hi)) * 16384;
    return bbn_pkg::norm_t'(num / span);
  endfunction

  task automatic clear_bounds();
    mesh_count = 0;
    lo_x = bbn_pkg::COORD_MAX;
    lo_y = bbn_pkg::COORD_MAX;
    lo_z = bbn_pkg::COORD_MAX;
    hi_x = bbn_pkg::COORD_MIN;
    hi_y = bbn_pkg::COORD_MIN;
    hi_z = bbn_pkg::COORD_MIN;
  endtask

  task automatic load_vertex(vertex_word_t w);
    longint     span;
    norm_word_t r;
    if (mesh_count < bbn_pkg::MAX_VERTICES) begin
      mesh_x[mesh_count] = w.x;
      mesh_y[mesh_count] = w.y;
      mesh_z[mesh_count] = w.z;
      mesh_count++;
      if (w.x < lo_x) lo_x = w.x;
      if (w.y < lo_y) lo_y = w.y;
      if (w.z < lo_z) lo_z = w.z;
      if (w.x > hi_x) hi_x = w.x;
      if (w.y > hi_y) hi_y = w.y;
      if (w.z > hi_z) hi_z = w.z;
    end
    if (w.last) begin
      span = longint'(hi_x) - longint'(lo_x);
      if (longint'(hi_y) - longint'(lo_y) > span) span = longint'(hi_y) - longint'(lo_y);
      if (longint'(hi_z) - longint'(lo_z) > span) span = longint'(hi_z) - longint'(lo_z);
      for (int i = 0; i < mesh_count; i++) begin
        if (span <= 0) begin
          r.x = '0;
          r.y = '0;
          r.z = '0;
          r.degen = 1'b1;
        end else begin
          r.x = scale_coord(mesh_x[i], lo_x, hi_x, span);
          r.y = scale_coord(mesh_y[i], lo_y, hi_y, span);
          r.z = scale_coord(mesh_z[i], lo_z, hi_z, span);
          r.degen = 1'b0;
        end
        r.last = (i == mesh_count - 1);
        norm_q.insert(norm_q.size(), r);
      end
      clear_bounds();
    end
  endtask

  task automatic add_word(bbn_pkg::coord_t x, bbn_pkg::coord_t y, bbn_pkg::coord_t z,
                          logic last, bit hold, int ph);
    vertex_word_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    w.last = last;
    w.hold = hold;
    w.phase = ph;
    vertex_q.insert(vertex_q.size(), w);
    total_words++;
  endtask

  function automatic bbn_pkg::coord_t pick_coord(mesh_kind_t kind, bbn_pkg::coord_t center,
                                                 int radius);
    longint v;
    case (kind)
      MESH_NARROW: begin
        v = longint'(center) + longint'($urandom_range(2 * radius)) - radius;
        if (v > longint'(bbn_pkg::COORD_MAX)) v = bbn_pkg::COORD_MAX;
        if (v < longint'(bbn_pkg::COORD_MIN)) v = bbn_pkg::COORD_MIN;
        return bbn_pkg::coord_t'(v);
      end
      MESH_FLAT: return center;
      MESH_EXTREME: begin
        case ($urandom_range(4))
          0: return bbn_pkg::COORD_MIN;
          1: return bbn_pkg::COORD_MAX;
          2: return bbn_pkg::coord_t'(0);
          3: return bbn_pkg::coord_t'(-1);
          default: return bbn_pkg::coord_t'($urandom_range(65535));
        endcase
      end
      default: return bbn_pkg::coord_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic add_mesh(int n, mesh_kind_t kind, bit hold, int ph);
    bbn_pkg::coord_t cx, cy, cz;
    int              radius;
    cx = bbn_pkg::coord_t'($urandom_range(65535));
    cy = bbn_pkg::coord_t'($urandom_range(65535));
    cz = bbn_pkg::coord_t'($urandom_range(65535));
    radius = $urandom_range(1, 200);
    for (int i = 0; i < n; i++) begin
      add_word(pick_coord(kind, cx, radius), pick_coord(kind, cy, radius),
               pick_coord(kind, cz, radius), i == n - 1, hold && (i == 0), ph);
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("ERROR %0t: %s", $time, what);
    err_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int         random_words;
    int         ovf_at;
    int         ph;
    int         prev_ph;
    int         n;
    int         r;
    mesh_kind_t kind;
    bit         ovf_done;
    clear_bounds();

    add_word(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 0);
    add_word(bbn_pkg::COORD_MAX, bbn_pkg::COORD_MIN, bbn_pkg::COORD_MAX, 1'b1, 1'b0, 0);
    add_word(bbn_pkg::COORD_MIN, bbn_pkg::COORD_MIN, bbn_pkg::COORD_MIN, 1'b0, 1'b0, 0);
    add_word(bbn_pkg::COORD_MAX, bbn_pkg::COORD_MAX, bbn_pkg::COORD_MAX, 1'b1, 1'b0, 0);
    add_word(16'sd5, -16'sd7, 16'sd100, 1'b0, 1'b0, 0);
    add_word(16'sd5, -16'sd7, 16'sd100, 1'b0, 1'b0, 0);
    add_word(16'sd5, -16'sd7, 16'sd100, 1'b1, 1'b0, 0);
    add_word(-16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0, 0);
    add_word(16'sd100, 16'sd10, -16'sd5, 1'b0, 1'b0, 0);
    add_word(16'sd0, -16'sd10, 16'sd5, 1'b1, 1'b0, 0);
    add_word(16'sd1, 16'sd2, -16'sd30000, 1'b0, 1'b0, 0);
    add_word(16'sd3, 16'sd4, 16'sd30000, 1'b1, 1'b0, 0);
    add_word(bbn_pkg::COORD_MAX, bbn_pkg::COORD_MIN, 16'sd0, 1'b0, 1'b0, 0);
    add_word(bbn_pkg::COORD_MIN, bbn_pkg::COORD_MAX, -16'sd1, 1'b0, 1'b0, 0);
    add_word(16'sd0, 16'sd0, bbn_pkg::COORD_MAX, 1'b0, 1'b0, 0);
    add_word(-16'sd1, -16'sd1, bbn_pkg::COORD_MIN, 1'b1, 1'b0, 0);
    add_word(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 0);
    add_word(16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 0);
    add_word(16'sd3, 16'sd0, 16'sd0, 1'b1, 1'b0, 0);
    add_word(16'sd7, 16'sd7, -16'sd9, 1'b0, 1'b0, 0);
    add_word(16'sd7, 16'sd7, 16'sd9, 1'b1, 1'b0, 0);

    random_words = 0;
    prev_ph = 0;
    ovf_done = 1'b0;
    ovf_at = $urandom_range(20, 120);
    while (random_words < 150) begin
      ph = (random_words * 4) / 150;
      if (ph > 3) ph = 3;
      if (!ovf_done && random_words >= ovf_at) begin
        ovf_done = 1'b1;
        add_mesh(bbn_pkg::MAX_VERTICES + 2, MESH_FULL, 1'b0, ph);
        random_words += bbn_pkg::MAX_VERTICES + 2;
      end else begin
        r = $urandom_range(99);
        n = (r < 80) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 20)
                                                       : $urandom_range(21, 40);
        r = $urandom_range(99);
        kind = (r < 60) ? MESH_FULL : (r < 80) ? MESH_NARROW : (r < 90) ? MESH_FLAT
                                                                        : MESH_EXTREME;
        add_mesh(n, kind, (ph != prev_ph) || (random_words == 0) || roll(10), ph);
        random_words += n;
      end
      prev_ph = ph;
    end

    wait (rst_n === 1'b1);
    @(posedge clk);
    while (taken_words != total_words || norm_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0 && norm_q.size() == 0) begin
      $display("bounding_box_normalizer_top regression: pass");
    end else begin
      $display("bounding_box_normalizer_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ERROR: run did not finish in time");
    $display("bounding_box_normalizer_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    bit free;
    bit idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        load_vertex(cur_word);
        taken_words++;
      end
      if (free) begin
        idle = 1'b1;
        if (vertex_q.size() != 0) begin
          idle = (vertex_q[0].phase == 1 && roll(83)) || (vertex_q[0].phase == 3 && roll(30))
              || (vertex_q[0].hold && norm_q.size() != 0);
        end
        if (!idle) begin
          cur_word = vertex_q.pop_front();
          drv_phase <= cur_word.phase;
          in_valid <= 1'b1;
          in_pos_x <= cur_word.x;
          in_pos_y <= cur_word.y;
          in_pos_z <= cur_word.z;
          in_last_vertex <= cur_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    norm_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (norm_q.size() == 0) begin
          flag_mismatch("result word with no expectation");
        end else begin
          e = norm_q.pop_front();
          if (out_norm_x !== e.x)
            flag_mismatch($sformatf("norm_x %0d, expected %0d", out_norm_x, e.x));
          if (out_norm_y !== e.y)
            flag_mismatch($sformatf("norm_y %0d, expected %0d", out_norm_y, e.y));
          if (out_norm_z !== e.z)
            flag_mismatch($sformatf("norm_z %0d, expected %0d", out_norm_z, e.z));
          if (out_degenerate !== e.degen)
            flag_mismatch($sformatf("degenerate %b, expected %b", out_degenerate, e.degen));
          if (out_last_out !== e.last)
            flag_mismatch($sformatf("last_out %b, expected %b", out_last_out, e.last));
        end
      end
      out_ready <= !((drv_phase == 2 && roll(83)) || (drv_phase == 3 && roll(30)));
    end
  end

endmodule
